// File: design/rna_pkg.sv
// Shared types and constants for the rational number ALU.
// No dependencies; imported by rna_front, rna_queue, rna_back and the top level.
package rna_pkg;

  localparam int unsigned MAX_W           = 32;
  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_OVF  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ORD_EQ = 2'b00,
    ORD_GT = 2'b01,
    ORD_LT = 2'b11
  } order_e;

  // back-end sequencer
  typedef enum logic [4:0] {
    S_IDLE, S_PA, S_PB, S_ORD,
    S_A_G, S_A_D1, S_A_D2, S_A_M1, S_A_M2, S_A_M3, S_A_M4,
    S_M_1, S_M_2, S_M_3,
    S_R_1, S_R_2, S_R_3, S_R_4, S_R_5, S_R_6, S_R_7, S_R_8,
    S_FIN_G, S_FIN_D1, S_FIN_D2, S_FIN_D3,
    S_WAIT, S_DONE
  } state_e;

  // classified operation, magnitudes zero-extended from VALUE_WIDTH bits
  typedef struct packed {
    op_e              op;
    logic             zden;
    logic             sa;
    logic             sb;
    logic [MAX_W-1:0] ma;
    logic [MAX_W-1:0] mb;
    logic [MAX_W-1:0] ua;
    logic [MAX_W-1:0] ub;
  } entry_t;

endpackage

// File: design/rna_if.sv
// Handshake interfaces for the operand and result channels.
// No dependencies.
interface rna_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic signed [1:0]  order;
  logic [1:0]         status;
  modport source (output valid, res_num, res_den, order, status, input ready);
  modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

// File: design/rna_front.sv
// Front end: accepts operands, moves denominator signs to the numerators,
// splits sign and magnitude, flags zero denominators. Uses rna_pkg, rna_if.
module rna_front import rna_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  rna_in_if.sink in_i,
  output logic   push_valid_o,
  input  logic   push_ready_i,
  output entry_t push_data_o
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [W-1:0] na, da, nb, db;
  logic [W-1:0] ma, mb, ua, ub;

  assign na = in_i.a_num[W-1:0];
  assign da = in_i.a_den[W-1:0];
  assign nb = in_i.b_num[W-1:0];
  assign db = in_i.b_den[W-1:0];

  assign ma = na[W-1] ? (~na + 1'b1) : na;
  assign mb = nb[W-1] ? (~nb + 1'b1) : nb;
  assign ua = da[W-1] ? (~da + 1'b1) : da;
  assign ub = db[W-1] ? (~db + 1'b1) : db;

  always_comb begin
    push_data_o.op   = op_e'(in_i.op);
    push_data_o.zden = (da == '0) || (db == '0);
    // negating the numerator flips its sign unless it is zero
    push_data_o.sa   = da[W-1] ? (!na[W-1] && (na != '0)) : na[W-1];
    push_data_o.sb   = db[W-1] ? (!nb[W-1] && (nb != '0)) : nb[W-1];
    push_data_o.ma   = MAX_W'(ma);
    push_data_o.mb   = MAX_W'(mb);
    push_data_o.ua   = MAX_W'(ua);
    push_data_o.ub   = MAX_W'(ub);
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// File: design/rna_queue.sv
// Short FIFO of classified operations between front and back end.
// Uses rna_pkg.
module rna_queue import rna_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: design/rna_gcd.sv
// Binary gcd unit, one step per cycle, result held until the next start.
// No package dependencies.
module rna_gcd #(
  parameter int unsigned MW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] a_i,
  input  logic [MW-1:0] b_i,
  output logic          busy_o,
  output logic [MW-1:0] g_o
);

  localparam int unsigned KW = $clog2(MW + 1);

  logic [MW-1:0] x_q, y_q, g_q;
  logic [KW-1:0] k_q;
  logic          busy_q;
  logic          fin;

  assign fin    = (x_q == '0) || (y_q == '0);
  assign busy_o = busy_q;
  assign g_o    = g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && fin) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= a_i;
      y_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (x_q == '0) begin
        g_q <= y_q << k_q;
      end else if (y_q == '0) begin
        g_q <= x_q << k_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
  end

endmodule

// File: design/rna_div.sv
// Restoring divider, one quotient bit per cycle; quotient and remainder
// held until the next start. No package dependencies.
module rna_div #(
  parameter int unsigned MW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] n_i,
  input  logic [MW-1:0] d_i,
  output logic          busy_o,
  output logic [MW-1:0] q_o,
  output logic [MW-1:0] r_o
);

  localparam int unsigned KW = $clog2(MW + 1);

  logic [MW-1:0] quo_q, rem_q, den_q;
  logic [KW-1:0] cnt_q;
  logic          busy_q;
  logic [MW:0]   sh;
  logic          ge;

  assign sh     = {rem_q, quo_q[MW-1]};
  assign ge     = (sh >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign q_o    = quo_q;
  assign r_o    = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= KW'(MW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == KW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= n_i;
      rem_q <= '0;
      den_q <= d_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[MW-2:0], ge};
      rem_q <= ge ? MW'(sh - {1'b0, den_q}) : sh[MW-1:0];
    end
  end

endmodule

// File: design/rna_back.sv
// Back end: sequencer over a shared gcd unit, divider and multiplier that
// reduces results and drives the result register. Uses rna_pkg, rna_if,
// rna_gcd, rna_div.
module rna_back import rna_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  entry_t     pop_data_i,
  rna_out_if.source  out_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned MW = 2 * VALUE_WIDTH;
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

  state_e state_q, state_d, ret_q, ret_d;

  op_e          op_q;
  logic         sa_q, sb_q, s_q;
  logic [W-1:0] ma_q, mb_q, ua_q, ub_q, t0_q, t1_q;
  logic [MW-1:0] m_q, den_q, prod_q;

  logic signed [31:0] st_num_q;
  logic [30:0]        st_den_q;
  logic [1:0]         st_ord_q;
  status_e            st_status_q;

  logic               out_valid_q;
  logic signed [31:0] res_num_q;
  logic [30:0]        res_den_q;
  logic [1:0]         res_ord_q;
  logic [1:0]         res_status_q;

  logic          gcd_start, gcd_busy;
  logic [MW-1:0] gcd_a, gcd_b, gcd_g;
  logic          div_start, div_busy;
  logic [MW-1:0] div_n, div_d, div_q, div_r;
  logic [W-1:0]  mul_a, mul_b;
  logic [MW-1:0] prod_d;
  logic          units_idle, out_free;

  rna_gcd #(.MW(MW)) u_gcd (
    .clk_i, .rst_ni, .start_i(gcd_start), .a_i(gcd_a), .b_i(gcd_b),
    .busy_o(gcd_busy), .g_o(gcd_g)
  );

  rna_div #(.MW(MW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .busy_o(div_busy), .q_o(div_q), .r_o(div_r)
  );

  assign prod_d     = MW'(mul_a) * MW'(mul_b);
  assign units_idle = !gcd_busy && !div_busy;
  assign out_free   = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == S_IDLE);

  // signed compare of a_num*b_den against b_num*a_den
  logic signed [MW:0] va, vb;
  logic               ord_lt, ord_eq;
  assign va = sa_q ? -$signed({1'b0, m_q})    : $signed({1'b0, m_q});
  assign vb = sb_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign ord_lt = (va < vb);
  assign ord_eq = (va == vb);

  // signed add/subtract of the scaled magnitudes
  logic          sbe, s_sum;
  logic [MW-1:0] m_sum;
  always_comb begin
    sbe = sb_q ^ (op_q == OP_SUB);
    if (sa_q == sbe) begin
      m_sum = m_q + prod_q;
      s_sum = sa_q;
    end else if (m_q >= prod_q) begin
      m_sum = m_q - prod_q;
      s_sum = sa_q;
    end else begin
      m_sum = prod_q - m_q;
      s_sum = sbe;
    end
  end

  // final range check on the reduced fraction
  logic          negf, ovf;
  logic [31:0]   mag32;
  always_comb begin
    negf  = s_q && (m_q != '0);
    ovf   = (div_q > LIM - 1'b1) || (negf ? (m_q > LIM) : (m_q > LIM - 1'b1));
    mag32 = 32'(m_q[W-1:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (pop_valid_i) state_d = pop_data_i.zden ? S_DONE : S_PA;
      S_PA:     state_d = S_PB;
      S_PB:     state_d = S_ORD;
      S_ORD: begin
        case (op_q)
          OP_ADD, OP_SUB: state_d = S_A_G;
          OP_MUL:         state_d = S_M_1;
          OP_DIV:         state_d = (mb_q == '0) ? S_DONE : S_M_1;
          OP_REM:         state_d = ord_lt ? S_FIN_G : (ord_eq ? S_DONE : S_R_1);
          default:        state_d = S_DONE;
        endcase
      end
      S_A_G, S_A_D1, S_A_D2, S_R_1, S_R_2, S_R_3, S_R_4, S_R_5, S_R_6,
      S_FIN_G, S_FIN_D1, S_FIN_D2: state_d = S_WAIT;
      S_A_M1:   state_d = S_A_M2;
      S_A_M2:   state_d = S_A_M3;
      S_A_M3:   state_d = S_A_M4;
      S_A_M4: begin
        if (op_q == OP_REM) state_d = (prod_q == '0) ? S_DONE : S_WAIT;
        else                state_d = S_FIN_G;
      end
      S_M_1:    state_d = S_M_2;
      S_M_2:    state_d = S_M_3;
      S_M_3:    state_d = S_FIN_G;
      S_R_7:    state_d = S_A_G;
      S_R_8:    state_d = S_FIN_G;
      S_FIN_D3: state_d = S_DONE;
      S_WAIT:   if (units_idle) state_d = ret_q;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    gcd_start = 1'b0;
    gcd_a     = '0;
    gcd_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = gcd_g;
    mul_a     = '0;
    mul_b     = '0;
    ret_d     = S_IDLE;
    case (state_q)
      S_PA:   begin mul_a = ma_q; mul_b = ub_q; end
      S_PB:   begin mul_a = mb_q; mul_b = ua_q; end
      S_A_G:  begin
        gcd_start = 1'b1; gcd_a = MW'(ua_q); gcd_b = MW'(ub_q); ret_d = S_A_D1;
      end
      S_A_D1: begin div_start = 1'b1; div_n = MW'(ua_q); ret_d = S_A_D2; end
      S_A_D2: begin div_start = 1'b1; div_n = MW'(ub_q); ret_d = S_A_M1; end
      S_A_M1: begin mul_a = t0_q; mul_b = ub_q; end
      S_A_M2: begin mul_a = ma_q; mul_b = t1_q; end
      S_A_M3: begin mul_a = mb_q; mul_b = t0_q; end
      S_A_M4: begin
        if (op_q == OP_REM && prod_q != '0) begin
          div_start = 1'b1; div_n = m_q; div_d = prod_q; ret_d = S_R_8;
        end
      end
      S_M_1:  begin mul_a = ma_q; mul_b = (op_q == OP_DIV) ? ub_q : mb_q; end
      S_M_2:  begin mul_a = ua_q; mul_b = (op_q == OP_DIV) ? mb_q : ub_q; end
      S_R_1:  begin
        gcd_start = 1'b1; gcd_a = MW'(ma_q); gcd_b = MW'(ua_q); ret_d = S_R_2;
      end
      S_R_2:  begin div_start = 1'b1; div_n = MW'(ma_q); ret_d = S_R_3; end
      S_R_3:  begin div_start = 1'b1; div_n = MW'(ua_q); ret_d = S_R_4; end
      S_R_4:  begin
        gcd_start = 1'b1; gcd_a = MW'(mb_q); gcd_b = MW'(ub_q); ret_d = S_R_5;
      end
      S_R_5:  begin div_start = 1'b1; div_n = MW'(mb_q); ret_d = S_R_6; end
      S_R_6:  begin div_start = 1'b1; div_n = MW'(ub_q); ret_d = S_R_7; end
      S_FIN_G: begin
        gcd_start = 1'b1; gcd_a = m_q; gcd_b = den_q; ret_d = S_FIN_D1;
      end
      S_FIN_D1: begin div_start = 1'b1; div_n = m_q;   ret_d = S_FIN_D2; end
      S_FIN_D2: begin div_start = 1'b1; div_n = den_q; ret_d = S_FIN_D3; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (gcd_start || div_start) ret_q <= ret_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == S_DONE && out_free) begin
      res_num_q    <= st_num_q;
      res_den_q    <= st_den_q;
      res_ord_q    <= st_ord_q;
      res_status_q <= st_status_q;
    end
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          op_q        <= pop_data_i.op;
          sa_q        <= pop_data_i.sa;
          sb_q        <= pop_data_i.sb;
          ma_q        <= pop_data_i.ma[W-1:0];
          mb_q        <= pop_data_i.mb[W-1:0];
          ua_q        <= pop_data_i.ua[W-1:0];
          ub_q        <= pop_data_i.ub[W-1:0];
          st_num_q    <= '0;
          st_den_q    <= '0;
          st_ord_q    <= ORD_EQ;
          st_status_q <= pop_data_i.zden ? STAT_ZERO : STAT_OK;
        end
      end
      S_PB: m_q <= prod_q;
      S_ORD: begin
        st_ord_q <= ord_lt ? ORD_LT : (ord_eq ? ORD_EQ : ORD_GT);
        case (op_q)
          OP_DIV: if (mb_q == '0) st_status_q <= STAT_ZERO;
          OP_REM: begin
            if (ord_lt) begin
              m_q   <= MW'(ma_q);
              den_q <= MW'(ua_q);
              s_q   <= sa_q;
            end else if (ord_eq) begin
              st_den_q <= 31'd1;
            end
          end
          default: ;
        endcase
      end
      S_A_D2: t0_q  <= div_q[W-1:0];
      S_A_M1: t1_q  <= div_q[W-1:0];
      S_A_M2: den_q <= prod_q;
      S_A_M3: m_q   <= prod_q;
      S_A_M4: begin
        if (op_q == OP_REM) begin
          if (prod_q == '0) st_status_q <= STAT_ZERO;
        end else begin
          m_q <= m_sum;
          s_q <= s_sum;
        end
      end
      S_M_2: m_q <= prod_q;
      S_M_3: begin
        den_q <= prod_q;
        s_q   <= sa_q ^ sb_q;
      end
      S_R_3: ma_q <= div_q[W-1:0];
      S_R_4: ua_q <= div_q[W-1:0];
      S_R_6: mb_q <= div_q[W-1:0];
      S_R_7: ub_q <= div_q[W-1:0];
      S_R_8: begin
        m_q <= div_r;
        s_q <= sa_q;
      end
      S_FIN_D2: m_q <= div_q;
      S_FIN_D3: begin
        if (ovf) begin
          st_num_q    <= '0;
          st_den_q    <= '0;
          st_status_q <= STAT_OVF;
        end else begin
          st_num_q    <= negf ? -$signed(mag32) : $signed(mag32);
          st_den_q    <= 31'(div_q[W-2:0]);
          st_status_q <= STAT_OK;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = res_num_q;
  assign out_o.res_den = res_den_q;
  assign out_o.order   = res_ord_q;
  assign out_o.status  = res_status_q;

  a_wait_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && units_idle) |=> (state_q == $past(ret_q)))
    else $error("sequencer did not return after unit finished");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(gcd_start && div_start))
    else $error("gcd and divider started together");

  a_gcd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gcd_start || div_start) |-> units_idle)
    else $error("unit restarted while busy");

endmodule

// File: design/rational_number_alu.sv
// The binary gcd unit (one step per cycle, up to four calls per operation)
//   and the 2*VALUE_WIDTH-bit divider, called up to nine times in sequence
//   for remainder, set the time an operation takes; a zero denominator or a
//   compare uses neither.
// Throughput: one operation at a time in the back end; two more can wait.
// Reset: asynchronous, active low; clears queue, sequencer and output valid.
module rational_number_alu import rna_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rna_in_if.sink    in_i,
  rna_out_if.source out_o
);

  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  rna_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_i, .push_valid_o(push_valid), .push_ready_i(push_ready),
    .push_data_o(push_data)
  );

  rna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_data),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_data)
  );

  rna_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready), .pop_data_i(pop_data),
    .out_o
  );

endmodule
